### src/bba_pkg.sv
// Shared constants, types and helper function of the buddy block allocator.
package bba_pkg;

    localparam int TABLE_DEPTH = 16384;
    localparam int TOP_LEVEL   = 40;
    localparam int ADDR_BITS   = 48;
    localparam int LEN_W       = 48;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LINK_W      = IDX_W + 1;
    localparam int LV_W        = 6;
    localparam int MIN_BLOCK   = 4096;
    localparam int MIN_LEVEL   = 12;

    localparam int MK_FREE  = 0;
    localparam int MK_SPLIT = 1;
    localparam int MK_WAS   = 2;
    localparam int MK_RIGHT = 3;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_MEM   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef logic [4:0] cmd_t;

    localparam cmd_t C_NOP   = 5'd0;
    localparam cmd_t C_LOAD  = 5'd1;
    localparam cmd_t C_LVDEC = 5'd2;
    localparam cmd_t C_PUT   = 5'd3;
    localparam cmd_t C_SRD   = 5'd4;
    localparam cmd_t C_SEV   = 5'd5;
    localparam cmd_t C_PRD   = 5'd6;
    localparam cmd_t C_PHOLD = 5'd7;
    localparam cmd_t C_PUTL  = 5'd8;
    localparam cmd_t C_PUTR  = 5'd9;
    localparam cmd_t C_MARKP = 5'd10;
    localparam cmd_t C_RSEV  = 5'd11;
    localparam cmd_t C_TWRD  = 5'd12;
    localparam cmd_t C_TWW   = 5'd13;
    localparam cmd_t C_ADONE = 5'd14;
    localparam cmd_t C_FSET  = 5'd15;
    localparam cmd_t C_CEV   = 5'd16;
    localparam cmd_t C_TRD   = 5'd17;
    localparam cmd_t C_TEV   = 5'd18;
    localparam cmd_t C_WC    = 5'd19;
    localparam cmd_t C_WT    = 5'd20;
    localparam cmd_t C_WP    = 5'd21;
    localparam cmd_t C_ENOM  = 5'd22;
    localparam cmd_t C_EADR  = 5'd23;
    localparam cmd_t C_EFUL  = 5'd24;
    localparam cmd_t C_EMIT  = 5'd25;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [LV_W-1:0]      level;
        logic [3:0]           marks;
        logic [LINK_W-1:0]    parent;
        logic [LINK_W-1:0]    twin;
    } node_t;

    typedef struct packed {
        logic [1:0] op;
        logic       len_gt;
        logic       lv_fits;
        logic       full;
        logic       k_end;
        logic       scan_stop;
        logic       found;
        logic       brk;
        logic       no_split;
        logic       was;
        logic       room;
        logic       rs_hit;
        logic       tw_ok;
        logic       parent_ok;
        logic       mg_c_ok;
        logic       mg_t_ok;
        logic       pp_ok;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [ADDR_BITS-1:0] lvl_size(input logic [LV_W-1:0] lv);
        lvl_size = (lv < LV_W'(ADDR_BITS)) ? (ADDR_BITS'(1) << lv) : '0;
    endfunction

endpackage

### src/buddy_block_allocator_core.sv
// Top level of the buddy block allocator: stream ports, sequencer and node table.
//
// One transaction is handled at a time and gives exactly one result transaction.
// Add-region creates its nodes one by one, the time mostly spent
// in the level search, which steps down one level per cycle from the level below the top level.
// Allocate and free first scan the node table entries in use one at a time,
// limited by the single read port of the table memory; an allocate then splits
// level by level, and a split that reuses earlier children rescans the table.
// A free merges upward level by level. No clearing pass is needed after reset.
module buddy_block_allocator_core import bba_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], address[49:2], length[97:50], zero fill above
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], block_address[49:2], block_size[97:50], zero fill above
    output logic [103:0] m_tdata
);

    dp_stat_t             stat;
    cmd_t                 cmd;
    logic [1:0]           m_status;
    logic [ADDR_BITS-1:0] m_addr;
    logic [LEN_W-1:0]     m_size;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_op    (s_tdata[1:0]),
        .in_addr  (s_tdata[49:2]),
        .in_len   (s_tdata[97:50]),
        .cmd      (cmd),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_status (m_status),
        .m_addr   (m_addr),
        .m_size   (m_size)
    );

    assign m_tdata = {6'd0, m_size, m_addr, m_status};

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice without finishing a transaction");

    a_result_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while a transaction is still in work");

    a_load_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == C_LOAD) |-> (s_tvalid && s_tready))
        else $error("load command outside an accepted transaction");
`endif

endmodule

### src/bba_ctrl.sv
// Operation sequencer of the buddy block allocator.
module bba_ctrl import bba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output cmd_t     cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_ACHK  = 5'd2;
    localparam logic [4:0] S_ALV   = 5'd3;
    localparam logic [4:0] S_APUT  = 5'd4;
    localparam logic [4:0] S_SRD   = 5'd5;
    localparam logic [4:0] S_SEV   = 5'd6;
    localparam logic [4:0] S_SEND  = 5'd7;
    localparam logic [4:0] S_SPRD  = 5'd8;
    localparam logic [4:0] S_SPEV  = 5'd9;
    localparam logic [4:0] S_PUTL  = 5'd10;
    localparam logic [4:0] S_PUTR  = 5'd11;
    localparam logic [4:0] S_MARKP = 5'd12;
    localparam logic [4:0] S_RSRD  = 5'd13;
    localparam logic [4:0] S_RSEV  = 5'd14;
    localparam logic [4:0] S_RSTW  = 5'd15;
    localparam logic [4:0] S_RSTWW = 5'd16;
    localparam logic [4:0] S_ADONE = 5'd17;
    localparam logic [4:0] S_FRRD  = 5'd18;
    localparam logic [4:0] S_FRSET = 5'd19;
    localparam logic [4:0] S_MRDC  = 5'd20;
    localparam logic [4:0] S_MEVC  = 5'd21;
    localparam logic [4:0] S_MRDT  = 5'd22;
    localparam logic [4:0] S_MEVT  = 5'd23;
    localparam logic [4:0] S_MWC   = 5'd24;
    localparam logic [4:0] S_MWT   = 5'd25;
    localparam logic [4:0] S_MWP   = 5'd26;
    localparam logic [4:0] S_ENOM  = 5'd27;
    localparam logic [4:0] S_EADR  = 5'd28;
    localparam logic [4:0] S_EFUL  = 5'd29;
    localparam logic [4:0] S_FIN   = 5'd30;

    logic [4:0] state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = C_NOP;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd        = C_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                unique case (stat.op)
                    OP_ADD:   state_next = S_ACHK;
                    OP_ALLOC: state_next = S_SRD;
                    OP_FREE:  state_next = S_SRD;
                    default:  state_next = S_FIN;
                endcase
            end
            S_ACHK: state_next = stat.len_gt ? S_ALV : S_FIN;
            S_ALV: begin
                cmd        = C_LVDEC;
                state_next = stat.lv_fits ? S_APUT : S_ALV;
            end
            S_APUT: begin
                cmd        = C_PUT;
                state_next = stat.full ? S_FIN : S_ACHK;
            end
            S_SRD: begin
                cmd        = C_SRD;
                state_next = stat.k_end ? S_SEND : S_SEV;
            end
            S_SEV: begin
                cmd        = C_SEV;
                state_next = stat.scan_stop ? S_SEND : S_SRD;
            end
            S_SEND: begin
                if (stat.op == OP_ALLOC) begin
                    state_next = stat.found ? S_SPRD : S_ENOM;
                end else begin
                    state_next = stat.found ? S_FRRD : S_EADR;
                end
            end
            S_SPRD: begin
                cmd        = C_PRD;
                state_next = S_SPEV;
            end
            S_SPEV: begin
                cmd = C_PHOLD;
                priority if (stat.brk || stat.no_split) begin
                    state_next = S_ADONE;
                end else if (stat.was) begin
                    state_next = S_RSRD;
                end else if (stat.room) begin
                    state_next = S_PUTL;
                end else begin
                    state_next = S_EFUL;
                end
            end
            S_PUTL: begin
                cmd        = C_PUTL;
                state_next = S_PUTR;
            end
            S_PUTR: begin
                cmd        = C_PUTR;
                state_next = S_MARKP;
            end
            S_MARKP: begin
                cmd        = C_MARKP;
                state_next = S_SPRD;
            end
            S_RSRD: begin
                cmd        = C_SRD;
                state_next = stat.k_end ? S_ADONE : S_RSEV;
            end
            S_RSEV: begin
                cmd        = C_RSEV;
                state_next = stat.rs_hit ? S_RSTW : S_RSRD;
            end
            S_RSTW: begin
                cmd        = C_TWRD;
                state_next = stat.tw_ok ? S_RSTWW : S_MARKP;
            end
            S_RSTWW: begin
                cmd        = C_TWW;
                state_next = S_MARKP;
            end
            S_ADONE: begin
                cmd        = C_ADONE;
                state_next = S_FIN;
            end
            S_FRRD: begin
                cmd        = C_PRD;
                state_next = S_FRSET;
            end
            S_FRSET: begin
                cmd        = C_FSET;
                state_next = stat.parent_ok ? S_MRDC : S_FIN;
            end
            S_MRDC: begin
                cmd        = C_PRD;
                state_next = S_MEVC;
            end
            S_MEVC: begin
                cmd        = C_CEV;
                state_next = stat.mg_c_ok ? S_MRDT : S_FIN;
            end
            S_MRDT: begin
                cmd        = C_TRD;
                state_next = S_MEVT;
            end
            S_MEVT: begin
                cmd        = C_TEV;
                state_next = stat.mg_t_ok ? S_MWC : S_FIN;
            end
            S_MWC: begin
                cmd        = C_WC;
                state_next = S_MWT;
            end
            S_MWT: begin
                cmd        = C_WT;
                state_next = S_MWP;
            end
            S_MWP: begin
                cmd        = C_WP;
                state_next = stat.pp_ok ? S_MRDC : S_FIN;
            end
            S_ENOM: begin
                cmd        = C_ENOM;
                state_next = S_FIN;
            end
            S_EADR: begin
                cmd        = C_EADR;
                state_next = S_FIN;
            end
            S_EFUL: begin
                cmd        = C_EFUL;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd = C_EMIT;
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### src/bba_dp.sv
// Node table, working registers and result register of the buddy block allocator.
module bba_dp import bba_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       in_op,
    input  logic [ADDR_BITS-1:0] in_addr,
    input  logic [LEN_W-1:0] in_len,
    input  cmd_t             cmd,
    input  logic             m_tready,
    output dp_stat_t         stat,
    output logic             m_tvalid,
    output logic [1:0]       m_status,
    output logic [ADDR_BITS-1:0] m_addr,
    output logic [LEN_W-1:0] m_size
);

    node_t mem [TABLE_DEPTH];
    node_t rd_reg;

    logic [1:0]           op_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [LINK_W-1:0]    count_reg;
    logic [LINK_W-1:0]    k_reg;
    logic [LV_W-1:0]      lv_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [IDX_W-1:0]     aux_reg;
    logic [IDX_W-1:0]     tw_reg;
    logic [LINK_W-1:0]    link_reg;
    logic [LEN_W-1:0]     best_reg;
    logic                 found_reg;
    node_t                pent_reg;
    node_t                cent_reg;
    node_t                twent_reg;
    logic [1:0]           status_reg;
    logic [ADDR_BITS-1:0] res_addr_reg;
    logic [LEN_W-1:0]     res_size_reg;
    logic                 m_tvalid_reg;
    logic [1:0]           m_status_reg;
    logic [ADDR_BITS-1:0] m_addr_reg;
    logic [LEN_W-1:0]     m_size_reg;

    logic                 we;
    logic [IDX_W-1:0]     wa;
    logic [IDX_W-1:0]     ra;
    node_t                wd;
    logic [LEN_W-1:0]     rd_size;
    logic [LEN_W-1:0]     lv_size;
    logic                 alloc_hit;
    logic                 free_hit;
    logic [LINK_W-1:0]    pick_link;
    logic [LV_W-1:0]      child_lv;

    function automatic logic link_ok(input logic [LINK_W-1:0] v,
                                     input logic [LINK_W-1:0] cnt);
        link_ok = (v != '0) && (v <= cnt);
    endfunction

    function automatic logic [IDX_W-1:0] link_idx(input logic [LINK_W-1:0] v);
        logic [LINK_W-1:0] t;
        t        = v - LINK_W'(1);
        link_idx = t[IDX_W-1:0];
    endfunction

    assign rd_size   = lvl_size(rd_reg.level);
    assign lv_size   = lvl_size(lv_reg);
    assign pick_link = {1'b0, pick_reg} + LINK_W'(1);
    assign child_lv  = pent_reg.level - LV_W'(1);
    assign alloc_hit = (rd_size >= len_reg) && (!found_reg || rd_size < best_reg)
                       && rd_reg.marks[MK_FREE];
    assign free_hit  = (rd_reg.addr == addr_reg) && !rd_reg.marks[MK_SPLIT];

    always_comb begin
        stat.op        = op_reg;
        stat.len_gt    = len_reg > LEN_W'(MIN_BLOCK);
        stat.lv_fits   = lv_size <= len_reg;
        stat.full      = count_reg >= LINK_W'(TABLE_DEPTH);
        stat.k_end     = k_reg >= count_reg;
        stat.scan_stop = (op_reg == OP_ALLOC) ? (alloc_hit && rd_size == len_reg) : free_hit;
        stat.found     = found_reg;
        stat.brk       = ((len_reg <= rd_size) && ((rd_reg.level == '0) ||
                         (lvl_size(rd_reg.level - LV_W'(1)) < len_reg))) ||
                         (rd_size == LEN_W'(MIN_BLOCK));
        stat.no_split  = (rd_reg.level == '0) || !rd_reg.marks[MK_FREE];
        stat.was       = rd_reg.marks[MK_WAS];
        stat.room      = ({1'b0, count_reg} + (LINK_W+1)'(2)) <= (LINK_W+1)'(TABLE_DEPTH);
        stat.rs_hit    = (rd_reg.parent == pick_link) && !rd_reg.marks[MK_RIGHT];
        stat.tw_ok     = link_ok(link_reg, count_reg);
        stat.parent_ok = link_ok(rd_reg.parent, count_reg);
        stat.mg_c_ok   = link_ok(rd_reg.twin, count_reg) && rd_reg.marks[MK_FREE];
        stat.mg_t_ok   = rd_reg.marks[MK_FREE] && link_ok(cent_reg.parent, count_reg);
        stat.pp_ok     = link_ok(rd_reg.parent, count_reg);
        stat.out_free  = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        we = 1'b0;
        wa = count_reg[IDX_W-1:0];
        wd = rd_reg;
        ra = pick_reg;
        case (cmd)
            C_PUT: begin
                we        = !stat.full;
                wd.addr   = addr_reg;
                wd.level  = lv_reg;
                wd.marks  = 4'b0001 << MK_FREE;
                wd.parent = '0;
                wd.twin   = '0;
            end
            C_SRD: ra = k_reg[IDX_W-1:0];
            C_PUTL: begin
                we        = 1'b1;
                wd.addr   = pent_reg.addr;
                wd.level  = child_lv;
                wd.marks  = 4'b0001 << MK_FREE;
                wd.parent = pick_link;
                wd.twin   = count_reg + LINK_W'(2);
            end
            C_PUTR: begin
                we        = 1'b1;
                wd.addr   = pent_reg.addr + lvl_size(child_lv);
                wd.level  = child_lv;
                wd.marks  = (4'b0001 << MK_FREE) | (4'b0001 << MK_RIGHT);
                wd.parent = pick_link;
                wd.twin   = count_reg;
            end
            C_MARKP: begin
                we       = 1'b1;
                wa       = pick_reg;
                wd       = pent_reg;
                wd.marks = (pent_reg.marks | (4'b0001 << MK_SPLIT) | (4'b0001 << MK_WAS))
                           & ~(4'b0001 << MK_FREE);
            end
            C_RSEV: begin
                we                 = stat.rs_hit;
                wa                 = k_reg[IDX_W-1:0];
                wd.marks[MK_FREE]  = 1'b1;
            end
            C_TWRD: ra = link_idx(link_reg);
            C_TWW: begin
                we                = 1'b1;
                wa                = link_idx(link_reg);
                wd.marks[MK_FREE] = 1'b1;
            end
            C_ADONE: begin
                we                = 1'b1;
                wa                = pick_reg;
                wd                = pent_reg;
                wd.marks[MK_FREE] = 1'b0;
            end
            C_FSET: begin
                we                = 1'b1;
                wa                = pick_reg;
                wd.marks[MK_FREE] = 1'b1;
            end
            C_TRD: ra = tw_reg;
            C_WC: begin
                we                = 1'b1;
                wa                = pick_reg;
                wd                = cent_reg;
                wd.marks[MK_FREE] = 1'b0;
            end
            C_WT: begin
                we                = 1'b1;
                wa                = tw_reg;
                wd                = twent_reg;
                wd.marks[MK_FREE] = 1'b0;
                ra                = link_idx(cent_reg.parent);
            end
            C_WP: begin
                we                 = 1'b1;
                wa                 = link_idx(cent_reg.parent);
                wd.marks[MK_SPLIT] = 1'b0;
                wd.marks[MK_WAS]   = 1'b1;
                wd.marks[MK_FREE]  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[ra];
    end

    always_ff @(posedge aclk) begin
        case (cmd)
            C_LOAD: begin
                op_reg       <= in_op;
                addr_reg     <= in_addr;
                len_reg      <= (in_op == OP_ALLOC && in_len < LEN_W'(MIN_BLOCK)) ?
                                LEN_W'(MIN_BLOCK) : in_len;
                k_reg        <= '0;
                found_reg    <= 1'b0;
                lv_reg       <= LV_W'(TOP_LEVEL - 1);
                status_reg   <= ST_OK;
                res_addr_reg <= '0;
                res_size_reg <= '0;
            end
            C_LVDEC: begin
                if (!stat.lv_fits) begin
                    lv_reg <= lv_reg - LV_W'(1);
                end
            end
            C_PUT: begin
                if (stat.full) begin
                    status_reg <= ST_FULL;
                end else begin
                    addr_reg <= addr_reg + lv_size;
                    len_reg  <= len_reg - lv_size;
                    lv_reg   <= LV_W'(TOP_LEVEL - 1);
                end
            end
            C_SEV: begin
                k_reg <= k_reg + LINK_W'(1);
                if (op_reg == OP_ALLOC ? alloc_hit : free_hit) begin
                    found_reg <= 1'b1;
                    best_reg  <= rd_size;
                    pick_reg  <= k_reg[IDX_W-1:0];
                end
            end
            C_PHOLD: begin
                pent_reg <= rd_reg;
                k_reg    <= '0;
            end
            C_PUTL: aux_reg <= count_reg[IDX_W-1:0];
            C_MARKP: pick_reg <= aux_reg;
            C_RSEV: begin
                k_reg <= k_reg + LINK_W'(1);
                if (stat.rs_hit) begin
                    aux_reg  <= k_reg[IDX_W-1:0];
                    link_reg <= rd_reg.twin;
                end
            end
            C_ADONE: begin
                res_addr_reg <= pent_reg.addr;
                res_size_reg <= lvl_size(pent_reg.level);
            end
            C_CEV: begin
                cent_reg <= rd_reg;
                tw_reg   <= link_idx(rd_reg.twin);
            end
            C_TEV: twent_reg <= rd_reg;
            C_WP: pick_reg <= link_idx(cent_reg.parent);
            C_ENOM: status_reg <= ST_NO_MEM;
            C_EADR: status_reg <= ST_NOT_FOUND;
            C_EFUL: status_reg <= ST_FULL;
            C_EMIT: begin
                if (stat.out_free) begin
                    m_status_reg <= status_reg;
                    m_addr_reg   <= res_addr_reg;
                    m_size_reg   <= res_size_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((cmd == C_PUT && !stat.full) || cmd == C_PUTL || cmd == C_PUTR) begin
                count_reg <= count_reg + LINK_W'(1);
            end
            if (cmd == C_EMIT && stat.out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_status = m_status_reg;
    assign m_addr   = m_addr_reg;
    assign m_size   = m_size_reg;

endmodule

### bench/buddy_block_allocator_checker.sv
// Checker for the buddy block allocator: watches both channels, predicts and compares.
module buddy_block_allocator_checker import bba_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    output int           fail_count,
    output int           pending,
    output int           results_seen
);

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] baddr;
        logic [47:0] bsize;
    } outcome_t;

    logic [47:0] t_addr [TABLE_DEPTH];
    logic [5:0]  t_level [TABLE_DEPTH];
    logic [3:0]  t_marks [TABLE_DEPTH];
    int          t_parent [TABLE_DEPTH];
    int          t_twin [TABLE_DEPTH];
    int          t_count;
    outcome_t    expected_q[$];

    function automatic logic [47:0] block_bytes(input int lv);
        return (lv < 48) ? (48'd1 << lv) : 48'd0;
    endfunction

    function automatic int link_idx(input int v);
        if (v == 0 || v > t_count) return -1;
        return v - 1;
    endfunction

    function automatic int add_node(input logic [47:0] a, input int lv);
        int i;
        i = t_count;
        if (i >= TABLE_DEPTH) return -1;
        t_addr[i] = a;
        t_level[i] = lv[5:0];
        t_marks[i] = 4'b0001;
        t_parent[i] = 0;
        t_twin[i] = 0;
        t_count = i + 1;
        return i;
    endfunction

    function automatic int level_for(input logic [47:0] n);
        int p;
        p = MIN_LEVEL;
        while (p < TOP_LEVEL && block_bytes(p) <= n) p++;
        return p - 1;
    endfunction

    function automatic int split_one(input int i);
        int lv, l, r;
        lv = t_level[i];
        if (block_bytes(lv) == 48'(MIN_BLOCK) || lv == 0 || !t_marks[i][MK_FREE]) return i;
        if (!t_marks[i][MK_WAS]) begin
            if (t_count + 2 > TABLE_DEPTH) return -2;
            l = add_node(t_addr[i], lv - 1);
            r = add_node(t_addr[i] + block_bytes(lv - 1), lv - 1);
            t_marks[r][MK_RIGHT] = 1'b1;
            t_parent[l] = i + 1;
            t_parent[r] = i + 1;
            t_twin[l] = r + 1;
            t_twin[r] = l + 1;
        end else begin
            l = -1;
            for (int k = 0; k < t_count; k++) begin
                if (t_parent[k] == i + 1 && !t_marks[k][MK_RIGHT]) begin
                    l = k;
                    break;
                end
            end
            if (l < 0) return i;
            t_marks[l][MK_FREE] = 1'b1;
            r = link_idx(t_twin[l]);
            if (r >= 0) t_marks[r][MK_FREE] = 1'b1;
        end
        t_marks[i][MK_SPLIT] = 1'b1;
        t_marks[i][MK_WAS] = 1'b1;
        t_marks[i][MK_FREE] = 1'b0;
        return l;
    endfunction

    function automatic void merge_twins(input int start);
        int cur, tw, par;
        cur = start;
        for (int it = 0; it < TABLE_DEPTH; it++) begin
            tw = link_idx(t_twin[cur]);
            if (tw < 0 || !t_marks[cur][MK_FREE] || !t_marks[tw][MK_FREE]) return;
            par = link_idx(t_parent[cur]);
            if (par < 0) return;
            t_marks[cur][MK_FREE] = 1'b0;
            t_marks[tw][MK_FREE] = 1'b0;
            t_marks[par][MK_SPLIT] = 1'b0;
            t_marks[par][MK_WAS] = 1'b1;
            t_marks[par][MK_FREE] = 1'b1;
            if (link_idx(t_parent[par]) < 0) return;
            cur = par;
        end
    endfunction

    function automatic outcome_t allocator_outcome(input logic [1:0] op,
                                                   input logic [47:0] addr,
                                                   input logic [47:0] len);
        outcome_t o;
        logic [47:0] best, s;
        int pick, lv, nx, hit;
        o = '0;
        if (op == OP_ADD) begin
            while (len > 48'(MIN_BLOCK)) begin
                lv = level_for(len);
                if (add_node(addr, lv) < 0) begin
                    o.status = ST_FULL;
                    break;
                end
                addr = addr + block_bytes(lv);
                len = len - block_bytes(lv);
            end
        end else if (op == OP_ALLOC) begin
            best = '1;
            pick = -1;
            if (len < 48'(MIN_BLOCK)) len = 48'(MIN_BLOCK);
            for (int k = 0; k < t_count; k++) begin
                s = block_bytes(t_level[k]);
                if (s >= len && s < best && t_marks[k][MK_FREE]) begin
                    best = s;
                    pick = k;
                    if (s == len) break;
                end
            end
            if (pick < 0) begin
                o.status = ST_NO_MEM;
            end else begin
                forever begin
                    lv = t_level[pick];
                    if ((len <= block_bytes(lv) && (lv == 0 || block_bytes(lv - 1) < len)) ||
                        block_bytes(lv) == 48'(MIN_BLOCK)) break;
                    nx = split_one(pick);
                    if (nx == -2) begin
                        o.status = ST_FULL;
                        return o;
                    end
                    if (nx == pick) break;
                    pick = nx;
                end
                t_marks[pick][MK_FREE] = 1'b0;
                o.baddr = t_addr[pick];
                o.bsize = block_bytes(t_level[pick]);
            end
        end else if (op == OP_FREE) begin
            hit = -1;
            for (int k = 0; k < t_count; k++) begin
                if (t_addr[k] == addr && !t_marks[k][MK_SPLIT]) begin
                    hit = k;
                    break;
                end
            end
            if (hit < 0) begin
                o.status = ST_NOT_FOUND;
            end else begin
                t_marks[hit][MK_FREE] = 1'b1;
                if (link_idx(t_parent[hit]) >= 0) merge_twins(hit);
            end
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        outcome_t got, want;
        if (!aresetn) begin
            t_count = 0;
            fail_count <= 0;
            results_seen <= 0;
            expected_q.delete();
            pending = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_q.push_back(allocator_outcome(s_tdata[1:0], s_tdata[49:2],
                                                       s_tdata[97:50]));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[1:0], m_tdata[49:2], m_tdata[97:50]};
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("Unexpected result transaction %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want || m_tdata[103:98] !== 6'd0) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("Mismatch: status %0d/%0d addr %h/%h size %h/%h (exp/got)",
                                     want.status, got.status, want.baddr, got.baddr,
                                     want.bsize, got.bsize);
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

### bench/buddy_block_allocator_core_test.sv
// Top of the buddy block allocator testbench: clock, reset, stimulus and verdict.
module buddy_block_allocator_core_test;
    import bba_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    int           fail_count;
    int           pending;
    int           results_seen;
    int           sender_idle;
    int           receiver_idle;
    int           hold_cycles;
    logic         hold_go;
    logic         hold_taken;
    int           items_sent;
    logic [47:0]  handed_out[$];

    buddy_block_allocator_core uut (.*);

    buddy_block_allocator_checker checker_i (.*);

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cycles <= 0;
            hold_taken <= 1'b0;
            m_tready <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cycles <= 50000;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [47:0] addr,
                             input logic [47:0] len);
        while ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, len, addr, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic random_item();
        int pick;
        logic [47:0] a;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_item(OP_ADD, {8'($urandom_range(255)), 40'd0},
                      48'($urandom_range(1 << 22)) << $urandom_range(6));
        end else if (pick < 55) begin
            send_item(OP_ALLOC, 48'd0, 48'($urandom_range(1 << 20)) >> $urandom_range(12));
        end else if (pick < 90 && handed_out.size() > 0) begin
            a = handed_out[$urandom_range(handed_out.size() - 1)];
            send_item(OP_FREE, a, 48'($urandom));
        end else if (pick < 95) begin
            send_item(OP_UNUSED, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
        end else begin
            send_item(OP_FREE, 48'({$urandom, $urandom}), 48'd0);
        end
    endtask

    always @(posedge aclk)
        if (m_tvalid && m_tready && m_tdata[1:0] == ST_OK && m_tdata[97:50] != 0)
            handed_out.push_back(m_tdata[49:2]);

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        hold_go = 1'b0;
        items_sent = 0;
        sender_idle = 9;
        receiver_idle = 56;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(OP_ALLOC, 48'd0, 48'd0);
        send_item(OP_FREE, 48'hFFFF_FFFF_FFFF, 48'd0);
        send_item(OP_ADD, 48'd0, 48'd4096);
        send_item(OP_ADD, 48'hFFFF_FFFF_0000, 48'h0000_0010_1000);
        send_item(OP_ADD, 48'h0000_1000_0000, 48'h0000_0040_3001);
        send_item(OP_ADD, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(OP_ALLOC, 48'd0, 48'd1);
        send_item(OP_ALLOC, 48'd0, 48'd4097);
        send_item(OP_ALLOC, 48'd0, 48'h0000_0010_0000);
        send_item(OP_ALLOC, 48'd0, 48'hFFFF_FFFF_FFFF);
        send_item(OP_FREE, 48'h0000_1000_0000, 48'd0);
        send_item(OP_FREE, 48'h0000_1000_0000, 48'd0);
        send_item(OP_ALLOC, 48'd0, 48'd8192);
        send_item(OP_FREE, 48'h0000_1000_0000, 48'hFFFF_FFFF_FFFF);
        send_item(OP_ALLOC, 48'd0, 48'd4096);
        send_item(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_item(OP_FREE, 48'h1234_5678_9ABC, 48'd0);
        drain();

        for (int k = 0; k < 40; k++) random_item();
        hold_go = 1'b1;
        for (int k = 0; k < 6; k++) random_item();
        sender_idle = 56;
        receiver_idle = 9;
        for (int k = 0; k < 20; k++) random_item();
        sender_idle = 0;
        receiver_idle = 0;
        for (int k = 0; k < 20; k++) random_item();
        drain();
        repeat (50) @(posedge aclk);

        $display("Sent %0d transactions of add, allocate, free and unused codes; %0d results.",
                 items_sent, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #400000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
